// ===== sv/sv39ptm_pkg.sv =====
// package for the sv39 page table mapper: pool sizing, codes and shared types
// no dependencies
package sv39ptm_pkg;

	// pool geometry
	localparam int POOL_FRAMES = 256;
	localparam int FRAME_W     = $clog2(POOL_FRAMES);
	localparam int HEAD_W      = $clog2(POOL_FRAMES + 1);
	localparam int IDX_W       = 9;
	localparam int MEM_AW      = FRAME_W + IDX_W;
	localparam int PN_W        = 44;
	localparam int APN_W       = 29;

	// opcodes
	localparam logic [1:0] OP_FREE  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_WALK  = 2'd2;
	localparam logic [1:0] OP_MAP   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_MISSING = 3'd1;
	localparam logic [2:0] ST_BADFREE = 3'd2;
	localparam logic [2:0] ST_REMAP   = 3'd3;
	localparam logic [2:0] ST_OUTSIDE = 3'd4;

	// pte valid flag
	localparam logic [9:0] PTE_V = 10'd1;

	// free list commands
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [FRAME_W-1:0] frame;
	} fl_ctl_t;

	// frame store access
	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [63:0]       wdata;
	} mem_req_t;

endpackage

// ===== sv/sv39ptm_frame_mem.sv =====
// frame store: all pool frames as 64-bit pte words, one access per cycle
// depends on sv39ptm_pkg
module sv39ptm_frame_mem (
	input  logic                  clk,
	input  sv39ptm_pkg::mem_req_t req,
	output logic [63:0]           rdata
);

	logic [63:0] mem [0:(1 << sv39ptm_pkg::MEM_AW)-1];

	// read-first single port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

// ===== sv/sv39ptm_free_list.sv =====
// lifo free list: link memory plus head register
// depends on sv39ptm_pkg
module sv39ptm_free_list (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sv39ptm_pkg::fl_ctl_t              ctl,
	output logic [sv39ptm_pkg::HEAD_W-1:0]    head,
	output logic                              head_valid
);

	logic [sv39ptm_pkg::HEAD_W-1:0] link [0:sv39ptm_pkg::POOL_FRAMES-1];
	logic [sv39ptm_pkg::HEAD_W-1:0] head_q;
	logic [sv39ptm_pkg::HEAD_W-1:0] next_q;

	// link memory, read continuously at the head
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			link[ctl.frame] <= head_q;
		end
		next_q <= link[head_q[sv39ptm_pkg::FRAME_W-1:0]];
	end

	// head register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= sv39ptm_pkg::HEAD_W'(sv39ptm_pkg::POOL_FRAMES);
		end else if (ctl.push) begin
			head_q <= sv39ptm_pkg::HEAD_W'(ctl.frame);
		end else if (ctl.pop) begin
			head_q <= next_q;
		end
	end

	assign head       = head_q;
	assign head_valid = (head_q < sv39ptm_pkg::HEAD_W'(sv39ptm_pkg::POOL_FRAMES));

endmodule

// ===== sv/sv39_page_table_mapper_unit.sv =====
// top level of the sv39 page table mapper: control sequencer and config registers
// depends on sv39ptm_pkg, sv39ptm_frame_mem, sv39ptm_free_list
//
// channel   handshake               payload
// req       req_valid / req_stall   opcode phys_addr root_addr virt_addr map_size
//                                   perm_bits create_missing
// rsp       rsp_valid / rsp_stall   status result_addr pte_value
// cfg       cfg_valid / cfg_ready   cfg_index cfg_data
//
// one word at a time; allocate zero-fills all 512 words of the new frame through
// the frame store port, one word per cycle. a walk reads one entry per table level
// and zero-fills and links each directory it creates; a map repeats root check and
// walk for each page. reset empties the free list and sets both config registers
// to 0x8000_0000; the frame store needs no clearing. a waiting result is held while
// the next word is taken in and worked on.
module sv39_page_table_mapper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [55:0] phys_addr,
	input  logic [55:0] root_addr,
	input  logic [38:0] virt_addr,
	input  logic [39:0] map_size,
	input  logic [9:0]  perm_bits,
	input  logic        create_missing,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [55:0] result_addr,
	output logic [63:0] pte_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [55:0] cfg_data
);

	localparam int FW = sv39ptm_pkg::FRAME_W;
	localparam int PW = sv39ptm_pkg::PN_W;
	localparam int AW = sv39ptm_pkg::APN_W;

	typedef enum logic [3:0] {
		S_IDLE, S_FREE, S_ALLOC, S_ZERO, S_DIR_WR, S_ROOT, S_RD, S_CHK,
		S_LEAF_RD, S_LEAF_CHK, S_DONE
	} state_t;

	state_t state_q;

	logic [55:0]   pool_base_q, low_limit_q;
	logic [1:0]    op_q;
	logic [PW-1:0] pa_pn_q;
	logic [11:0]   pa_lo_q;
	logic [PW-1:0] root_pn_q;
	logic [AW-1:0] apn_q, last_q;
	logic [9:0]    perm_q;
	logic          create_q;
	logic [FW-1:0] cur_f_q, g_q;
	logic          lvl2_q;
	logic [8:0]    zcnt_q;
	logic [2:0]    pend_status_q;
	logic [55:0]   pend_addr_q;
	logic [63:0]   pend_pte_q;
	logic          rsp_valid_q;
	logic [2:0]    status_q;
	logic [55:0]   result_addr_q;
	logic [63:0]   pte_value_q;

	sv39ptm_pkg::fl_ctl_t  fl_ctl;
	sv39ptm_pkg::mem_req_t mem_req;
	logic [sv39ptm_pkg::HEAD_W-1:0] fl_head;
	logic          fl_valid;
	logic [63:0]   mem_rdata;

	logic [PW-1:0] base_pn;
	logic [40:0]   last_addr;
	logic [8:0]    vpn_sel, vpn0;
	logic          root_in, pte_in, free_in;
	logic [FW-1:0] root_off, pte_off, free_off;
	logic [PW-1:0] pte_pn;
	logic          req_acc;

	// page number to pool frame: hit flag and offset
	function automatic logic in_pool(input logic [PW-1:0] pn, input logic [PW-1:0] base);
		logic [PW-1:0] diff;
		diff = pn - base;
		return (pn >= base) && (diff < PW'(sv39ptm_pkg::POOL_FRAMES));
	endfunction

	function automatic logic [FW-1:0] pool_off(input logic [PW-1:0] pn,
		input logic [PW-1:0] base);
		logic [PW-1:0] diff;
		diff = pn - base;
		return diff[FW-1:0];
	endfunction

	assign base_pn   = pool_base_q[55:12];
	assign last_addr = {2'b0, virt_addr} + {1'b0, map_size} - 41'd1;
	assign vpn_sel   = lvl2_q ? apn_q[26:18] : apn_q[17:9];
	assign vpn0      = apn_q[8:0];
	assign pte_pn    = mem_rdata[53:10];
	assign root_in   = in_pool(root_pn_q, base_pn);
	assign root_off  = pool_off(root_pn_q, base_pn);
	assign pte_in    = in_pool(pte_pn, base_pn);
	assign pte_off   = pool_off(pte_pn, base_pn);
	assign free_in   = in_pool(pa_pn_q, base_pn);
	assign free_off  = pool_off(pa_pn_q, base_pn);
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// free list commands
	always_comb begin
		fl_ctl.push  = 1'b0;
		fl_ctl.pop   = 1'b0;
		fl_ctl.frame = free_off;
		case (state_q)
			S_FREE: begin
				fl_ctl.push = ({pa_pn_q, pa_lo_q} >= low_limit_q) && (pa_lo_q == 12'd0)
					&& free_in;
			end
			S_ALLOC: begin
				fl_ctl.pop = fl_valid;
			end
			S_CHK: begin
				fl_ctl.pop = !mem_rdata[0] && create_q && fl_valid;
			end
			default: begin
			end
		endcase
	end

	// frame store access
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = {cur_f_q, vpn_sel};
		mem_req.wdata = 64'd0;
		case (state_q)
			S_ZERO: begin
				mem_req.we   = 1'b1;
				mem_req.addr = {g_q, zcnt_q};
			end
			S_DIR_WR: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {10'd0, base_pn + PW'(g_q), sv39ptm_pkg::PTE_V};
			end
			S_LEAF_RD: begin
				mem_req.addr = {cur_f_q, vpn0};
			end
			S_LEAF_CHK: begin
				mem_req.addr  = {cur_f_q, vpn0};
				mem_req.we    = (op_q == sv39ptm_pkg::OP_MAP) && !mem_rdata[0];
				mem_req.wdata = {10'd0, pa_pn_q, perm_q | sv39ptm_pkg::PTE_V};
			end
			default: begin
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= 56'h8000_0000;
			low_limit_q <= 56'h8000_0000;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index) begin
				low_limit_q <= cfg_data;
			end else begin
				pool_base_q <= cfg_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						op_q          <= opcode;
						pa_pn_q       <= phys_addr[55:12];
						pa_lo_q       <= phys_addr[11:0];
						root_pn_q     <= root_addr[55:12];
						apn_q         <= {2'b0, virt_addr[38:12]};
						last_q        <= last_addr[40:12];
						perm_q        <= perm_bits;
						create_q      <= create_missing || (opcode == sv39ptm_pkg::OP_MAP);
						pend_status_q <= sv39ptm_pkg::ST_OK;
						pend_addr_q   <= 56'd0;
						pend_pte_q    <= 64'd0;
						case (opcode)
							sv39ptm_pkg::OP_FREE:  state_q <= S_FREE;
							sv39ptm_pkg::OP_ALLOC: state_q <= S_ALLOC;
							sv39ptm_pkg::OP_WALK:  state_q <= S_ROOT;
							default: state_q <= (map_size == 40'd0) ? S_DONE : S_ROOT;
						endcase
					end
				end
				S_FREE: begin
					if (pa_lo_q != 12'd0 || {pa_pn_q, pa_lo_q} < low_limit_q) begin
						pend_status_q <= sv39ptm_pkg::ST_BADFREE;
					end else if (!free_in) begin
						pend_status_q <= sv39ptm_pkg::ST_OUTSIDE;
					end
					state_q <= S_DONE;
				end
				S_ALLOC: begin
					g_q    <= fl_head[FW-1:0];
					zcnt_q <= 9'd0;
					if (fl_valid) begin
						state_q <= S_ZERO;
					end else begin
						pend_status_q <= sv39ptm_pkg::ST_MISSING;
						state_q       <= S_DONE;
					end
				end
				S_ZERO: begin
					zcnt_q <= zcnt_q + 9'd1;
					if (zcnt_q == 9'd511) begin
						if (op_q == sv39ptm_pkg::OP_ALLOC) begin
							pend_addr_q <= {base_pn + PW'(g_q), 12'd0};
							state_q     <= S_DONE;
						end else begin
							state_q <= S_DIR_WR;
						end
					end
				end
				S_DIR_WR: begin
					cur_f_q <= g_q;
					lvl2_q  <= 1'b0;
					state_q <= lvl2_q ? S_RD : S_LEAF_RD;
				end
				S_ROOT: begin
					cur_f_q <= root_off;
					lvl2_q  <= 1'b1;
					if (root_in) begin
						state_q <= S_RD;
					end else begin
						pend_status_q <= sv39ptm_pkg::ST_OUTSIDE;
						state_q       <= S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (mem_rdata[0]) begin
						cur_f_q <= pte_off;
						lvl2_q  <= 1'b0;
						if (!pte_in) begin
							pend_status_q <= sv39ptm_pkg::ST_OUTSIDE;
							state_q       <= S_DONE;
						end else begin
							state_q <= lvl2_q ? S_RD : S_LEAF_RD;
						end
					end else if (create_q && fl_valid) begin
						// take a new directory frame, zero it, then link it
						g_q     <= fl_head[FW-1:0];
						zcnt_q  <= 9'd0;
						state_q <= S_ZERO;
					end else begin
						pend_status_q <= sv39ptm_pkg::ST_MISSING;
						state_q       <= S_DONE;
					end
				end
				S_LEAF_RD: begin
					state_q <= S_LEAF_CHK;
				end
				S_LEAF_CHK: begin
					if (op_q == sv39ptm_pkg::OP_WALK) begin
						pend_addr_q <= {base_pn + PW'(cur_f_q), vpn0, 3'd0};
						pend_pte_q  <= mem_rdata;
						state_q     <= S_DONE;
					end else if (mem_rdata[0]) begin
						pend_status_q <= sv39ptm_pkg::ST_REMAP;
						state_q       <= S_DONE;
					end else if (apn_q == last_q) begin
						state_q <= S_DONE;
					end else begin
						apn_q   <= apn_q + AW'(1);
						pa_pn_q <= pa_pn_q + PW'(1);
						state_q <= S_ROOT;
					end
				end
				S_DONE: begin
					// hand over once the output register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q   <= 1'b1;
						status_q      <= pend_status_q;
						result_addr_q <= pend_addr_q;
						pte_value_q   <= pend_pte_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign result_addr = result_addr_q;
	assign pte_value   = pte_value_q;

	sv39ptm_frame_mem u_frame_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	sv39ptm_free_list u_free_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fl_ctl),
		.head       (fl_head),
		.head_valid (fl_valid)
	);

endmodule

// ===== dv/tb_sv39_page_table_mapper_unit.sv =====
// testbench for sv39_page_table_mapper_unit: directed and random free, allocate, walk and map
// words checked against an in-bench model of the frame pool; depends on sv39ptm_pkg and sv39_page_table_mapper_unit
`timescale 1ns / 100ps

module tb_sv39_page_table_mapper_unit;

	localparam int          WATCHDOG_LIMIT = 50000;
	localparam int          FRAMES         = sv39ptm_pkg::POOL_FRAMES;
	localparam logic [55:0] ADDR_MAX       = 56'hFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]  op;
		logic [55:0] pa;
		logic [55:0] root;
		logic [38:0] va;
		logic [39:0] size;
		logic [9:0]  perm;
		logic        create;
	} map_req_t;

	typedef struct {
		logic [2:0]  st;
		logic [55:0] addr;
		logic [63:0] pte;
	} map_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  opcode = sv39ptm_pkg::OP_FREE;
	logic [55:0] phys_addr = '0;
	logic [55:0] root_addr = '0;
	logic [38:0] virt_addr = '0;
	logic [39:0] map_size = '0;
	logic [9:0]  perm_bits = '0;
	logic        create_missing = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [2:0]  status;
	logic [55:0] result_addr;
	logic [63:0] pte_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [55:0] cfg_data = '0;

	sv39_page_table_mapper_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .phys_addr(phys_addr), .root_addr(root_addr),
		.virt_addr(virt_addr), .map_size(map_size), .perm_bits(perm_bits),
		.create_missing(create_missing),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .result_addr(result_addr), .pte_value(pte_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// pool model state
	logic [63:0]  pool_mem [0:FRAMES*512-1];
	int unsigned  link_of [0:FRAMES-1];
	int unsigned  list_head;
	bit           list_nonempty;
	bit [FRAMES-1:0] frame_init;
	logic [55:0]  pool_base_r;
	logic [55:0]  low_limit_r;
	bit           hit_unwritten;
	int unsigned  undo_idx [$];
	logic [63:0]  undo_val [$];

	map_rsp_t     pending_rsp [$];
	int           errors;
	int           idle_pct;
	int           stall_pct;
	bit           req_on;
	int           quiet_cycles;

	function automatic logic [55:0] frame_base();
		return {pool_base_r[55:12], 12'h0};
	endfunction

	function automatic bit pool_frame(logic [55:0] a, output int unsigned f);
		logic [55:0] off;
		f = 0;
		if (a < frame_base())
			return 0;
		off = (a - frame_base()) >> 12;
		if (off >= FRAMES)
			return 0;
		f = int'(off);
		return 1;
	endfunction

	function automatic logic [55:0] frame_addr(int unsigned f);
		return frame_base() + 56'(f) * 56'h1000;
	endfunction

	// reads of never-written frames flag the word as unusable
	function automatic logic [63:0] mem_rd(int unsigned i);
		if (!frame_init[i / 512]) begin
			hit_unwritten = 1;
			return '0;
		end
		return pool_mem[i];
	endfunction

	function automatic void mem_wr(int unsigned i, logic [63:0] v);
		undo_idx.push_back(i);
		undo_val.push_back(pool_mem[i]);
		pool_mem[i] = v;
	endfunction

	function automatic bit pop_frame(output int unsigned f);
		f = 0;
		if (!list_nonempty)
			return 0;
		f = list_head % FRAMES;
		list_head = link_of[f];
		list_nonempty = list_head < FRAMES;
		for (int j = 0; j < 512; j++)
			mem_wr(f * 512 + j, '0);
		frame_init[f] = 1;
		return 1;
	endfunction

	function automatic logic [2:0] table_walk(logic [55:0] root, logic [63:0] va, bit create,
		output int unsigned slot);
		int unsigned f, g, idx;
		logic [63:0] pte;
		logic [55:0] na;
		slot = 0;
		if (!pool_frame(root, f))
			return sv39ptm_pkg::ST_OUTSIDE;
		for (int lv = 2; lv > 0; lv--) begin
			idx = f * 512 + int'((va >> (12 + 9 * lv)) & 64'h1FF);
			pte = mem_rd(idx);
			if (pte[0]) begin
				if (!pool_frame({pte[53:10], 12'h0}, f))
					return sv39ptm_pkg::ST_OUTSIDE;
			end else begin
				if (!create || !pop_frame(g))
					return sv39ptm_pkg::ST_MISSING;
				na = frame_addr(g);
				mem_wr(idx, {10'h0, na[55:12], sv39ptm_pkg::PTE_V});
				f = g;
			end
		end
		slot = f * 512 + int'((va >> 12) & 64'h1FF);
		return sv39ptm_pkg::ST_OK;
	endfunction

	// applies one word to the pool model; returns 0 and rolls back if it
	// would read a frame that was never written
	function automatic bit pool_apply(map_req_t r, output map_rsp_t e);
		int unsigned f, slot, sv_head;
		bit sv_ok;
		bit [FRAMES-1:0] sv_init;
		logic [63:0] a, last, cur;
		logic [55:0] pa;
		logic [2:0] s;
		e = '{sv39ptm_pkg::ST_OK, '0, '0};
		sv_head = list_head;
		sv_ok = list_nonempty;
		sv_init = frame_init;
		undo_idx.delete();
		undo_val.delete();
		hit_unwritten = 0;
		case (r.op)
			sv39ptm_pkg::OP_FREE: begin
				if (r.pa[11:0] != 0 || r.pa < low_limit_r)
					e.st = sv39ptm_pkg::ST_BADFREE;
				else if (!pool_frame(r.pa, f))
					e.st = sv39ptm_pkg::ST_OUTSIDE;
				else begin
					link_of[f] = list_nonempty ? list_head : FRAMES;
					list_head = f;
					list_nonempty = 1;
				end
			end
			sv39ptm_pkg::OP_ALLOC: begin
				if (pop_frame(f))
					e.addr = frame_addr(f);
				else
					e.st = sv39ptm_pkg::ST_MISSING;
			end
			sv39ptm_pkg::OP_WALK: begin
				e.st = table_walk(r.root, 64'(r.va), r.create, slot);
				if (e.st == sv39ptm_pkg::ST_OK) begin
					e.addr = frame_base() + 56'(slot) * 56'd8;
					e.pte = mem_rd(slot);
				end
			end
			default: begin
				if (r.size != 0) begin
					a = 64'(r.va) & ~64'hFFF;
					last = (64'(r.va) + 64'(r.size) - 1) & ~64'hFFF;
					pa = r.pa;
					forever begin
						s = table_walk(r.root, a, 1'b1, slot);
						if (hit_unwritten)
							break;
						if (s != sv39ptm_pkg::ST_OK) begin
							e.st = s;
							break;
						end
						cur = mem_rd(slot);
						if (hit_unwritten)
							break;
						if (cur[0]) begin
							e.st = sv39ptm_pkg::ST_REMAP;
							break;
						end
						mem_wr(slot, {10'h0, pa[55:12], 10'h0} | 64'(r.perm)
							| 64'(sv39ptm_pkg::PTE_V));
						if (a == last)
							break;
						a += 64'h1000;
						pa += 56'h1000;
					end
				end
			end
		endcase
		if (hit_unwritten) begin
			for (int i = undo_idx.size() - 1; i >= 0; i--)
				pool_mem[undo_idx[i]] = undo_val[i];
			list_head = sv_head;
			list_nonempty = sv_ok;
			frame_init = sv_init;
			return 0;
		end
		return 1;
	endfunction

	function automatic bit on_free_list(int unsigned f);
		int unsigned h;
		bit ok;
		h = list_head;
		ok = list_nonempty;
		for (int n = 0; n < FRAMES && ok; n++) begin
			if (h % FRAMES == f)
				return 1;
			h = link_of[h % FRAMES];
			ok = h < FRAMES;
		end
		return 0;
	endfunction

	// drive one word; skipped when the model cannot predict it
	task automatic send_word(map_req_t r, output bit sent);
		map_rsp_t e;
		sent = pool_apply(r, e);
		if (!sent)
			return;
		if (!req_on) begin
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= r.op;
		phys_addr <= r.pa;
		root_addr <= r.root;
		virt_addr <= r.va;
		map_size <= r.size;
		perm_bits <= r.perm;
		create_missing <= r.create;
		pending_rsp.push_back(e);
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		req_on = 1;
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			req_on = 0;
		end
	endtask

	task automatic send(logic [1:0] op, logic [55:0] pa, logic [55:0] root, logic [38:0] va,
		logic [39:0] size, logic [9:0] perm, logic create);
		bit sent;
		send_word('{op, pa, root, va, size, perm, create}, sent);
	endtask

	// stop sending and wait until every result is back
	task automatic drain();
		if (req_on) begin
			req_valid <= 1'b0;
			req_on = 0;
		end
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_config(logic [55:0] base, logic [55:0] limit);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= 1'b0;
		cfg_data <= base;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		pool_base_r = base;
		low_limit_r = limit;
	endtask

	function automatic logic [55:0] rand56();
		return 56'({$urandom, $urandom});
	endfunction

	function automatic logic [38:0] rand_va();
		if ($urandom_range(9) == 0)
			return 39'({$urandom, $urandom});
		return {27'($urandom_range(3)) << 18 | 27'($urandom_range(3)) << 9
			| 27'($urandom_range(511)), 12'($urandom_range(4095))};
	endfunction

	function automatic logic [55:0] rand_root();
		int unsigned f;
		if ($urandom_range(9) == 0)
			return rand56();
		for (int n = 0; n < 64; n++) begin
			f = $urandom_range(FRAMES - 1);
			if (frame_init[f])
				break;
		end
		return frame_addr(f) | 56'($urandom_range(4095));
	endfunction

	function automatic map_req_t rand_word();
		map_req_t r;
		int unsigned f, pick;
		r = '{sv39ptm_pkg::OP_FREE, rand56(), rand_root(), rand_va(), '0, 10'($urandom),
			1'($urandom)};
		pick = $urandom_range(99);
		if (pick < 30) begin
			r.op = sv39ptm_pkg::OP_FREE;
			if ($urandom_range(9) != 0) begin
				f = $urandom_range(FRAMES - 1);
				if (on_free_list(f))
					r.pa = ADDR_MAX;
				else
					r.pa = frame_addr(f);
			end
		end else if (pick < 45) begin
			r.op = sv39ptm_pkg::OP_ALLOC;
		end else if (pick < 70) begin
			r.op = sv39ptm_pkg::OP_WALK;
		end else begin
			r.op = sv39ptm_pkg::OP_MAP;
			if ($urandom_range(19) == 0) begin
				r.root = rand56() | 56'h80_0000_0000_0000;
				r.size = 40'({$urandom, $urandom});
			end else if ($urandom_range(9) == 0) begin
				r.size = '0;
			end else begin
				r.size = 40'($urandom_range(8 * 4096 - 1)) + 40'd1;
			end
		end
		return r;
	endfunction

	// freeing, allocating, walking and mapping corner cases at reset settings
	task automatic test_directed();
		logic [55:0] b, root;
		b = frame_base();
		root = b + 56'h7000;
		send(sv39ptm_pkg::OP_ALLOC, '0, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_FREE, b + 56'd1, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_FREE, b - 56'h1000, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_FREE, b + 56'h10_0000, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_FREE, ADDR_MAX, '0, '0, '0, '0, 1'b0);
		for (int f = 0; f < 8; f++)
			send(sv39ptm_pkg::OP_FREE, b + 56'(f) * 56'h1000, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_ALLOC, '0, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_WALK, '0, root, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_WALK, '0, root | 56'hFFF, '1, '0, '0, 1'b1);
		send(sv39ptm_pkg::OP_WALK, '0, '0, '0, '0, '0, 1'b1);
		send(sv39ptm_pkg::OP_MAP, 56'hFF_FFFF_FFFF_F123, root, 39'h1000, 40'h2000, 10'h3FF,
			1'b0);
		send(sv39ptm_pkg::OP_WALK, '0, root, 39'h2ABC, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_MAP, '0, root, 39'h1000, 40'h80_0000_0000, 10'h0, 1'b0);
		send(sv39ptm_pkg::OP_MAP, '0, ADDR_MAX, '0, '1, '1, 1'b1);
		send(sv39ptm_pkg::OP_MAP, '0, root, 39'h5000, '0, '1, 1'b0);
		send(sv39ptm_pkg::OP_WALK, '0, root, 39'h5000, '0, '0, 1'b0);
	endtask

	task automatic test_random(int count, int idle, int stall);
		bit sent;
		int n;
		idle_pct = idle;
		stall_pct = stall;
		n = 0;
		while (n < count) begin
			send_word(rand_word(), sent);
			if (sent)
				n++;
		end
	endtask

	// a second free of the same frame makes the list loop on itself
	task automatic test_double_free();
		logic [55:0] a;
		idle_pct = 0;
		stall_pct = 0;
		a = frame_addr(3);
		send(sv39ptm_pkg::OP_FREE, a, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_FREE, a, '0, '0, '0, '0, 1'b0);
		for (int n = 0; n < 3; n++)
			send(sv39ptm_pkg::OP_ALLOC, '0, '0, '0, '0, '0, 1'b0);
		send(sv39ptm_pkg::OP_WALK, '0, a, 39'h7F_FFFF_F000, '0, '0, 1'b1);
	endtask

	// receiver stall
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < stall_pct);

	// result check
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				map_rsp_t e;
				e = pending_rsp.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (result_addr !== e.addr) begin
					$error("result_addr expected %h actual %h", e.addr, result_addr);
					errors++;
				end
				if (pte_value !== e.pte) begin
					$error("pte_value expected %h actual %h", e.pte, pte_value);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sv39_page_table_mapper_unit test failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		req_on = 0;
		quiet_cycles = 0;
		list_head = FRAMES;
		list_nonempty = 0;
		frame_init = '0;
		pool_base_r = 56'h8000_0000;
		low_limit_r = 56'h8000_0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250, 0, 0);
		write_config('0, '0);
		test_random(250, 52, 0);
		write_config(56'hFF_FFFF_FFFF_F000, ADDR_MAX);
		test_random(150, 0, 52);
		write_config(56'h8000_0000, 56'h8000_0000);
		test_random(100, 0, 52);
		write_config(56'h12_3456_7000, 56'h12_3456_7000);
		test_random(250, 14, 14);
		test_double_free();
		drain();
		if (errors == 0)
			$display("sv39_page_table_mapper_unit test passed");
		else
			$display("sv39_page_table_mapper_unit test failed");
		$finish;
	end

endmodule
